FILE: rtl/core/efp_pkg.sv
package efp_pkg;

	localparam int unsigned LEN_W = 16;
	localparam int unsigned ADDR_W = 48;
	localparam int unsigned TYPE_W = 16;
	localparam int unsigned CRC_W = 8;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned TDATA_IN_W = 8;

	localparam logic [7:0] PREAMBLE_FILL = 8'hAA;
	localparam logic [7:0] PREAMBLE_SFD = 8'hAB;
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [2:0] PREAMBLE_RUN = 3'd7;
	localparam logic [3:0] HEADER_LAST = 4'd13;
	localparam logic [3:0] DEST_END = 4'd6;
	localparam logic [3:0] SRC_END = 4'd12;

	localparam logic CFG_MIN_LEN = 1'b0;
	localparam logic CFG_MAX_LEN = 1'b1;

	localparam logic [15:0] MIN_LEN_RESET = 16'd46;
	localparam logic [15:0] MAX_LEN_RESET = 16'd1500;

	typedef struct packed {
		logic accept;
		logic crc_ok;
		logic [CRC_W-1:0] crc_expected;
		logic [CRC_W-1:0] crc_received;
		logic [LEN_W-1:0] data_length;
		logic [TYPE_W-1:0] ether_type;
		logic [ADDR_W-1:0] src_address;
		logic [ADDR_W-1:0] dest_address;
		logic [LEN_W-1:0] frame_number;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);
	localparam int unsigned TDATA_OUT_W = ((RESULT_W + 7) / 8) * 8;

	localparam int unsigned CRC_OK_BIT = 160;
	localparam int unsigned ACCEPT_BIT = 161;
	localparam int unsigned RX_LO = 144;
	localparam int unsigned EXP_LO = 152;

	// One long-division step: the byte enters the remainder MSB first.
	function automatic logic [CRC_W-1:0] crc_shift(input logic [CRC_W-1:0] rem,
			input logic [BYTE_W-1:0] din);
		logic [CRC_W-1:0] r;
		logic top;
		r = rem;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			top = r[CRC_W-1];
			r = {r[CRC_W-2:0], din[i]};
			if (top) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/ethernet_frame_parser_crc8_core.sv
// A frame report is pushed into the result buffer, and from there presented on m_axis,
// by the byte that closes the frame (the 0xAB that completes the next preamble, or the final byte).
// Throughput: one byte per cycle; the preamble detector, header capture and the
// 8-step CRC update all keep pace with the input. s_axis_tready drops only while
// both slots of the two-entry result buffer are occupied.
// Reset: arst_n clears parsing state, frame number to 1, and length limits to 46/1500.
module ethernet_frame_parser_crc8_core #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [7:0] data_byte
	input  logic [efp_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
	// end_of_stream
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// frame_number, dest_address, src_address, ether_type, data_length,
	// crc_received, crc_expected, crc_ok, accept, zero fill
	output logic [efp_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [15:0]                         cfg_data
);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam int unsigned HIST_DEPTH = 9;

	logic [1:0]                   phase_q;
	logic [2:0]                   aa_run_q;
	logic [3:0]                   header_pos_q;
	logic [COUNT_WIDTH-1:0]       count_q;
	logic [15:0]                  frame_cnt_q;
	logic [15:0]                  min_len_q;
	logic [15:0]                  max_len_q;
	logic [efp_pkg::CRC_W-1:0]    crc_q;
	logic [efp_pkg::CRC_W-1:0]    hist_q [HIST_DEPTH];
	logic [efp_pkg::ADDR_W-1:0]   dest_q;
	logic [efp_pkg::ADDR_W-1:0]   src_q;
	logic [efp_pkg::TYPE_W-1:0]   type_q;

	logic                         in_fire;
	logic [7:0]                   din;
	logic                         eos;
	logic                         run_full;
	logic                         pre_hit;
	logic [2:0]                   aa_run_step;
	logic [efp_pkg::CRC_W-1:0]    crc_step;
	logic                         emit_pre;
	logic                         emit_eos;
	logic                         emit;
	logic [COUNT_WIDTH-1:0]       len;
	logic [15:0]                  dlen;
	logic [efp_pkg::CRC_W-1:0]    rem_before;
	logic [efp_pkg::CRC_W-1:0]    rem_after;
	logic [efp_pkg::CRC_W-1:0]    expected;
	logic [efp_pkg::CRC_W-1:0]    received;
	logic                         buf_full;
	efp_pkg::result_t             res;
	efp_pkg::result_t             out_res;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !buf_full;
	assign din = s_axis_tdata[7:0];
	assign eos = s_axis_tlast;

	assign run_full = (aa_run_q == efp_pkg::PREAMBLE_RUN);
	assign pre_hit = run_full && (din == efp_pkg::PREAMBLE_SFD);
	assign aa_run_step = (run_full || din != efp_pkg::PREAMBLE_FILL) ? 3'd0 : aa_run_q + 3'd1;
	assign crc_step = efp_pkg::crc_shift(crc_q, din);

	assign emit_pre = (phase_q == PH_DATA) && pre_hit && (count_q >= COUNT_WIDTH'(8));
	assign emit_eos = (phase_q == PH_DATA) && !pre_hit && eos;
	assign emit = in_fire && (emit_pre || emit_eos);

	always_comb begin
		if (emit_pre && count_q != COUNT_MAX) begin
			len = count_q - COUNT_WIDTH'(8);
		end else begin
			len = count_q;
		end
	end

	generate
		if (COUNT_WIDTH > 16) begin : g_clamp
			assign dlen = (|len[COUNT_WIDTH-1:16]) ? 16'hFFFF : len[15:0];
		end else begin : g_extend
			assign dlen = 16'(len);
		end
	endgenerate

	assign rem_before = emit_pre ? hist_q[8] : crc_q;
	assign rem_after = emit_pre ? hist_q[7] : crc_step;
	assign expected = efp_pkg::crc_shift(rem_before, 8'h00);
	assign received = emit_pre ? (hist_q[7] ^ expected) : din;

	always_comb begin
		res.frame_number = frame_cnt_q;
		res.dest_address = dest_q;
		res.src_address = src_q;
		res.ether_type = type_q;
		res.data_length = dlen;
		res.crc_received = received;
		res.crc_expected = expected;
		res.crc_ok = (rem_after == '0);
		res.accept = (rem_after == '0) && (dlen >= min_len_q) && (dlen <= max_len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= efp_pkg::MIN_LEN_RESET;
			max_len_q <= efp_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				efp_pkg::CFG_MIN_LEN: min_len_q <= cfg_data;
				efp_pkg::CFG_MAX_LEN: max_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			aa_run_q <= 3'd0;
			header_pos_q <= 4'd0;
			count_q <= '0;
			frame_cnt_q <= 16'd1;
		end else if (in_fire) begin
			if (eos) begin
				phase_q <= PH_HUNT;
				aa_run_q <= 3'd0;
				header_pos_q <= 4'd0;
				count_q <= '0;
				frame_cnt_q <= 16'd1;
			end else begin
				if (emit) begin
					frame_cnt_q <= frame_cnt_q + 16'd1;
				end
				case (phase_q)
					PH_HUNT: begin
						aa_run_q <= aa_run_step;
						if (pre_hit) begin
							phase_q <= PH_HEADER;
							header_pos_q <= 4'd0;
						end
					end
					PH_HEADER: begin
						if (header_pos_q >= efp_pkg::HEADER_LAST) begin
							phase_q <= PH_DATA;
							header_pos_q <= 4'd0;
							aa_run_q <= 3'd0;
							count_q <= '0;
						end else begin
							header_pos_q <= header_pos_q + 4'd1;
						end
					end
					PH_DATA: begin
						aa_run_q <= aa_run_step;
						if (pre_hit) begin
							phase_q <= PH_HEADER;
							header_pos_q <= 4'd0;
							aa_run_q <= 3'd0;
						end else if (count_q != COUNT_MAX) begin
							count_q <= count_q + COUNT_WIDTH'(1);
						end
					end
					default: begin
						phase_q <= PH_HUNT;
						aa_run_q <= 3'd0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (phase_q == PH_HEADER) begin
				crc_q <= (header_pos_q == 4'd0) ? din : crc_step;
				if (header_pos_q < efp_pkg::DEST_END) begin
					dest_q <= {dest_q[efp_pkg::ADDR_W-9:0], din};
				end else if (header_pos_q < efp_pkg::SRC_END) begin
					src_q <= {src_q[efp_pkg::ADDR_W-9:0], din};
				end else begin
					type_q <= {type_q[efp_pkg::TYPE_W-9:0], din};
				end
				if (header_pos_q >= efp_pkg::HEADER_LAST) begin
					for (int i = 0; i < HIST_DEPTH; i++) begin
						hist_q[i] <= (header_pos_q == 4'd0) ? din : crc_step;
					end
				end
			end else if (phase_q == PH_DATA && !pre_hit && !eos) begin
				crc_q <= crc_step;
				hist_q[0] <= crc_step;
				for (int i = 1; i < HIST_DEPTH; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
			end
		end
	end

	efp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (res),
		.full      (buf_full),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = {{(efp_pkg::TDATA_OUT_W - efp_pkg::RESULT_W){1'b0}}, out_res};

endmodule

FILE: rtl/core/efp_out_buf.sv
module efp_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  efp_pkg::result_t  push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output efp_pkg::result_t  out_data
);

	logic             head_valid_q;
	logic             skid_valid_q;
	efp_pkg::result_t head_q;
	efp_pkg::result_t skid_q;
	logic             pop;

	assign pop = head_valid_q && out_ready;
	assign full = skid_valid_q;
	assign out_valid = head_valid_q;
	assign out_data = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			if (head_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				head_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			if (head_valid_q) begin
				skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end
	end

endmodule

FILE: rtl/core/efp_checker.sv
module efp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [efp_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("Result request dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("Result payload changed while stalled.");

	a_accept_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tdata[efp_pkg::ACCEPT_BIT] ||
			m_axis_tdata[efp_pkg::CRC_OK_BIT]))
		else $error("Frame accepted with a bad CRC.");

	a_crc_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[efp_pkg::CRC_OK_BIT] ==
			(m_axis_tdata[efp_pkg::RX_LO +: 8] == m_axis_tdata[efp_pkg::EXP_LO +: 8])))
		else $error("CRC status disagrees with received and expected CRC.");

	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("Input stalled with no result request pending.");

endmodule

bind ethernet_frame_parser_crc8_core efp_checker u_efp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
